// ===== rtl/clock_face_pixel_generator_macros.svh =====
// assertion helpers shared by the clock face pixel generator
`ifndef CLOCK_FACE_PIXEL_GENERATOR_MACROS_SVH
`define CLOCK_FACE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, off during reset
`define CFPG_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define CFPG_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/cfpg_pkg.sv =====
package cfpg_pkg;

  // coordinate and register widths
  localparam int CW = 12;
  localparam int FW = CW + 1;
  localparam int SW = CW + 3;
  localparam int RX_W = 8;
  localparam int RY_W = 6;

  // clock layout
  localparam int GLYPH_ZOOM = 5;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int GLYPH_SPACE = 5;
  localparam int DOT_SIZE = 10;
  localparam int BTN_BOX = 18;
  localparam int BTN_OFFSET = 10;
  localparam int CLOCK_W_I = 6 * GLYPH_COLS * GLYPH_ZOOM + 2 * DOT_SIZE + 7 * GLYPH_SPACE;
  localparam int CLOCK_H_I = GLYPH_ROWS * GLYPH_ZOOM;
  localparam int GLYPH_W = GLYPH_COLS * GLYPH_ZOOM;
  localparam int PITCH = GLYPH_W + GLYPH_SPACE;
  localparam int COLON_PITCH = DOT_SIZE + GLYPH_SPACE;

  localparam logic [SW-1:0] CLOCK_W = SW'(CLOCK_W_I);
  localparam logic [SW-1:0] CLOCK_H = SW'(CLOCK_H_I);
  localparam logic [FW-1:0] FRAME_W_RST = FW'(640);
  localparam logic [FW-1:0] FRAME_H_RST = FW'(480);

  // register indexes
  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // column slots across the clock
  localparam logic [2:0] SLOT_D0 = 3'd0;
  localparam logic [2:0] SLOT_D1 = 3'd1;
  localparam logic [2:0] SLOT_D2 = 3'd2;
  localparam logic [2:0] SLOT_D3 = 3'd3;
  localparam logic [2:0] SLOT_D4 = 3'd4;
  localparam logic [2:0] SLOT_D5 = 3'd5;
  localparam logic [2:0] SLOT_COLON = 3'd6;
  localparam logic [2:0] SLOT_NONE = 3'd7;

  typedef enum logic [2:0] {
    PAINT_NONE,
    PAINT_BACK,
    PAINT_BORDER,
    PAINT_PANEL,
    PAINT_CLOSE,
    PAINT_TIME,
    PAINT_SECS
  } paint_t;

  localparam logic [4:0] FONT [0:9][0:6] = '{
    '{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e},
    '{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
    '{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
    '{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e},
    '{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
    '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e},
    '{5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
    '{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
    '{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e}
  };

  // stage one results
  typedef struct packed {
    logic valid;
    logic outside;
    logic border;
    logic panel;
    logic btn_in;
    logic [4:0] btn_dx;
    logic [4:0] btn_dy;
    logic clk_in;
    logic [RX_W-1:0] rx;
    logic [RY_W-1:0] ry;
    logic [5:0][3:0] digits;
  } front_t;

  // stage two results
  typedef struct packed {
    logic valid;
    logic outside;
    paint_t base;
    logic glyph_en;
    logic secs;
    logic [2:0] col;
    logic [2:0] row;
    logic [3:0] digit;
    logic colon_hit;
  } locate_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] col;
  } slot_t;

  // truncating centre origin: (v - span) / 2 toward zero
  function automatic logic signed [SW-1:0] origin(input logic [FW-1:0] v,
                                                  input logic [SW-1:0] span);
    logic signed [SW-1:0] d;
    d = $signed(SW'(v)) - $signed(span);
    return (d + $signed(SW'(d[SW-1]))) >>> 1;
  endfunction

  localparam logic signed [SW-1:0] X0_RST = origin(FRAME_W_RST, CLOCK_W);
  localparam logic signed [SW-1:0] Y0_RST = origin(FRAME_H_RST, CLOCK_H);

  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60) t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] t10;
    t10 = 6'({t, 3'b000}) + 6'({t, 1'b0});
    return 4'(v - t10);
  endfunction

  // scaled glyph column from offset inside a glyph
  function automatic logic [2:0] col_of(input logic [RX_W-1:0] off);
    logic [2:0] c;
    if (off < RX_W'(GLYPH_ZOOM)) c = 3'd0;
    else if (off < RX_W'(2 * GLYPH_ZOOM)) c = 3'd1;
    else if (off < RX_W'(3 * GLYPH_ZOOM)) c = 3'd2;
    else if (off < RX_W'(4 * GLYPH_ZOOM)) c = 3'd3;
    else c = 3'd4;
    return c;
  endfunction

  // which digit or colon a clock-relative column falls in
  function automatic slot_t slot_of(input logic [RX_W-1:0] rx);
    slot_t s;
    logic [RX_W-1:0] off;
    s.kind = SLOT_NONE;
    off = rx;
    if (rx < RX_W'(GLYPH_W)) begin
      s.kind = SLOT_D0;
      off = rx;
    end else if (rx >= RX_W'(PITCH) && rx < RX_W'(PITCH + GLYPH_W)) begin
      s.kind = SLOT_D1;
      off = rx - RX_W'(PITCH);
    end else if (rx >= RX_W'(2 * PITCH) && rx < RX_W'(2 * PITCH + DOT_SIZE)) begin
      s.kind = SLOT_COLON;
    end else if (rx >= RX_W'(2 * PITCH + COLON_PITCH) &&
                 rx < RX_W'(2 * PITCH + COLON_PITCH + GLYPH_W)) begin
      s.kind = SLOT_D2;
      off = rx - RX_W'(2 * PITCH + COLON_PITCH);
    end else if (rx >= RX_W'(3 * PITCH + COLON_PITCH) &&
                 rx < RX_W'(3 * PITCH + COLON_PITCH + GLYPH_W)) begin
      s.kind = SLOT_D3;
      off = rx - RX_W'(3 * PITCH + COLON_PITCH);
    end else if (rx >= RX_W'(4 * PITCH + COLON_PITCH) &&
                 rx < RX_W'(4 * PITCH + COLON_PITCH + DOT_SIZE)) begin
      s.kind = SLOT_COLON;
    end else if (rx >= RX_W'(4 * PITCH + 2 * COLON_PITCH) &&
                 rx < RX_W'(4 * PITCH + 2 * COLON_PITCH + GLYPH_W)) begin
      s.kind = SLOT_D4;
      off = rx - RX_W'(4 * PITCH + 2 * COLON_PITCH);
    end else if (rx >= RX_W'(5 * PITCH + 2 * COLON_PITCH) &&
                 rx < RX_W'(5 * PITCH + 2 * COLON_PITCH + GLYPH_W)) begin
      s.kind = SLOT_D5;
      off = rx - RX_W'(5 * PITCH + 2 * COLON_PITCH);
    end
    s.col = col_of(off);
    return s;
  endfunction

  function automatic logic [2:0] row_of(input logic [RY_W-1:0] ry);
    logic [2:0] r;
    if (ry < RY_W'(GLYPH_ZOOM)) r = 3'd0;
    else if (ry < RY_W'(2 * GLYPH_ZOOM)) r = 3'd1;
    else if (ry < RY_W'(3 * GLYPH_ZOOM)) r = 3'd2;
    else if (ry < RY_W'(4 * GLYPH_ZOOM)) r = 3'd3;
    else if (ry < RY_W'(5 * GLYPH_ZOOM)) r = 3'd4;
    else if (ry < RY_W'(6 * GLYPH_ZOOM)) r = 3'd5;
    else r = 3'd6;
    return r;
  endfunction

  // close button outline and x, offsets inside the 18x18 box
  function automatic logic close_mask(input logic [4:0] dx, input logic [4:0] dy);
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] e;
    logic edge_hit;
    logic diag;
    logic anti;
    a = {1'b0, dx};
    b = {1'b0, dy};
    e = 6'(BTN_BOX - 1) - a;
    edge_hit = (dy < 5'd2) || (dy >= 5'(BTN_BOX - 2)) ||
               (dx < 5'd2) || (dx >= 5'(BTN_BOX - 2));
    diag = (a >= 6'd5) && (a <= 6'd13) && (b >= 6'd5) && (b <= 6'd13) &&
           ((a == b) || (a == b + 6'd1) || (b == a + 6'd1));
    anti = (dx >= 5'd4) && (dx <= 5'd12) && (b >= 6'd5) && (b <= 6'd13) &&
           ((e == b) || (e == b + 6'd1) || (b == e + 6'd1));
    return edge_hit || diag || anti;
  endfunction

  function automatic logic font_bit(input logic [3:0] d, input logic [2:0] r,
                                    input logic [2:0] c);
    logic [4:0] bits;
    bits = 5'd0;
    if (d <= 4'd9 && r <= 3'd6 && c <= 3'd4) begin
      bits = FONT[d][r];
    end
    return (c <= 3'd4) ? bits[3'd4 - c] : 1'b0;
  endfunction

  function automatic logic [31:0] argb(input paint_t p);
    logic [31:0] c;
    case (p)
      PAINT_BACK: c = 32'hff101722;
      PAINT_PANEL: c = 32'hff182333;
      PAINT_BORDER: c = 32'hff38b2ac;
      PAINT_TIME: c = 32'hffedf2f7;
      PAINT_SECS: c = 32'hff63d5cf;
      PAINT_CLOSE: c = 32'hfffc8181;
      default: c = 32'h0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/clock_face_pixel_generator.sv =====
// an accepted request passes the front, locate and output registers in turn to out_valid
// throughput: one pixel per cycle while not stalled; three stages share one advance enable
// a stalled output holds every stage; in_ready is high whenever the output register is free
// reset: synchronous active-low rst_n clears all stage valid bits
// reset frame size is 640 x 480 and the clock origin follows it
`include "clock_face_pixel_generator_macros.svh"

module clock_face_pixel_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cfpg_pkg::CW-1:0]     in_pixel_x,
  input  logic [cfpg_pkg::CW-1:0]     in_pixel_y,
  input  logic [4:0]                  in_hour,
  input  logic [5:0]                  in_minute,
  input  logic [5:0]                  in_second,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_pixel_color,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [cfpg_pkg::FW-1:0]     cfg_data
);

  logic [cfpg_pkg::FW-1:0] frame_w_r;
  logic [cfpg_pkg::FW-1:0] frame_h_r;
  logic signed [cfpg_pkg::SW-1:0] org_x_r;
  logic signed [cfpg_pkg::SW-1:0] org_y_r;
  logic adv;
  cfpg_pkg::front_t front;
  cfpg_pkg::locate_t locate;

  // pipeline moves when the output register is free or being taken
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // frame registers and derived clock origin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= cfpg_pkg::FRAME_W_RST;
      frame_h_r <= cfpg_pkg::FRAME_H_RST;
      org_x_r <= cfpg_pkg::X0_RST;
      org_y_r <= cfpg_pkg::Y0_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cfpg_pkg::REG_FRAME_WIDTH: begin
          frame_w_r <= cfg_data;
          org_x_r <= cfpg_pkg::origin(cfg_data, cfpg_pkg::CLOCK_W);
        end
        cfpg_pkg::REG_FRAME_HEIGHT: begin
          frame_h_r <= cfg_data;
          org_y_r <= cfpg_pkg::origin(cfg_data, cfpg_pkg::CLOCK_H);
        end
        default: begin
        end
      endcase
    end
  end

  // region tests and digit split
  cfpg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .pixel_x  (in_pixel_x),
    .pixel_y  (in_pixel_y),
    .hour     (in_hour),
    .minute   (in_minute),
    .second   (in_second),
    .frame_w  (frame_w_r),
    .frame_h  (frame_h_r),
    .org_x    (org_x_r),
    .org_y    (org_y_r),
    .front    (front)
  );

  // layer select and glyph cell decode
  cfpg_locate u_locate (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .front  (front),
    .locate (locate)
  );

  // font lookup and output register
  cfpg_shade u_shade (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .locate          (locate),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color)
  );

  `CFPG_ASSERT_NXT(a_stall_holds, clk, rst_n, !adv, $stable({front.valid, locate.valid, out_valid}))
  `CFPG_ASSERT_NXT(a_accept_enters, clk, rst_n, in_valid && in_ready, front.valid)

endmodule

// ===== rtl/cfpg_front.sv =====
`include "clock_face_pixel_generator_macros.svh"

module cfpg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [cfpg_pkg::CW-1:0]       pixel_x,
  input  logic [cfpg_pkg::CW-1:0]       pixel_y,
  input  logic [4:0]                    hour,
  input  logic [5:0]                    minute,
  input  logic [5:0]                    second,
  input  logic [cfpg_pkg::FW-1:0]       frame_w,
  input  logic [cfpg_pkg::FW-1:0]       frame_h,
  input  logic signed [cfpg_pkg::SW-1:0] org_x,
  input  logic signed [cfpg_pkg::SW-1:0] org_y,
  output cfpg_pkg::front_t              front
);

  cfpg_pkg::front_t front_r;
  cfpg_pkg::front_t front_nxt;

  logic [cfpg_pkg::SW-1:0] px;
  logic [cfpg_pkg::SW-1:0] py;
  logic [cfpg_pkg::SW-1:0] fw;
  logic [cfpg_pkg::SW-1:0] fh;
  logic signed [cfpg_pkg::SW-1:0] rx;
  logic signed [cfpg_pkg::SW-1:0] ry;
  logic signed [cfpg_pkg::SW-1:0] bdx;
  logic [4:0] bdy;
  logic [2:0] ht;
  logic [2:0] mt;
  logic [2:0] st;

  assign px = cfpg_pkg::SW'(pixel_x);
  assign py = cfpg_pkg::SW'(pixel_y);
  assign fw = cfpg_pkg::SW'(frame_w);
  assign fh = cfpg_pkg::SW'(frame_h);

  // clock-relative and button-relative offsets
  assign rx = $signed(px) - org_x;
  assign ry = $signed(py) - org_y;
  assign bdx = $signed(px) - $signed(fw) +
               $signed(cfpg_pkg::SW'(cfpg_pkg::BTN_OFFSET + cfpg_pkg::BTN_BOX));
  assign bdy = 5'(py - cfpg_pkg::SW'(cfpg_pkg::BTN_OFFSET));

  // decimal split of the time fields
  assign ht = cfpg_pkg::tens_of({1'b0, hour});
  assign mt = cfpg_pkg::tens_of(minute);
  assign st = cfpg_pkg::tens_of(second);

  // frame, border, panel and region tests
  always_comb begin
    front_nxt.valid = in_valid;
    front_nxt.outside = (px >= fw) || (py >= fh);
    front_nxt.border = (px >= cfpg_pkg::SW'(2)) && (px + cfpg_pkg::SW'(2) < fw) &&
                       (py >= cfpg_pkg::SW'(2)) && (py + cfpg_pkg::SW'(2) < fh);
    front_nxt.panel = (px >= cfpg_pkg::SW'(5)) && (px + cfpg_pkg::SW'(5) < fw) &&
                      (py >= cfpg_pkg::SW'(5)) && (py + cfpg_pkg::SW'(5) < fh);
    front_nxt.btn_in = (bdx >= 0) &&
                       (bdx < $signed(cfpg_pkg::SW'(cfpg_pkg::BTN_BOX))) &&
                       (py >= cfpg_pkg::SW'(cfpg_pkg::BTN_OFFSET)) &&
                       (py < cfpg_pkg::SW'(cfpg_pkg::BTN_OFFSET +
                                           cfpg_pkg::BTN_BOX));
    front_nxt.btn_dx = bdx[4:0];
    front_nxt.btn_dy = bdy;
    front_nxt.clk_in = (rx >= 0) && (rx < $signed(cfpg_pkg::CLOCK_W)) &&
                       (ry >= 0) && (ry < $signed(cfpg_pkg::CLOCK_H));
    front_nxt.rx = rx[cfpg_pkg::RX_W-1:0];
    front_nxt.ry = ry[cfpg_pkg::RY_W-1:0];
    front_nxt.digits[0] = 4'(ht);
    front_nxt.digits[1] = cfpg_pkg::units_of({1'b0, hour}, ht);
    front_nxt.digits[2] = 4'(mt);
    front_nxt.digits[3] = cfpg_pkg::units_of(minute, mt);
    front_nxt.digits[4] = 4'(st);
    front_nxt.digits[5] = cfpg_pkg::units_of(second, st);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (adv) begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;

  `CFPG_ASSERT_IMP(a_panel_in_border, clk, rst_n, front_r.valid && front_r.panel, front_r.border)

endmodule

// ===== rtl/cfpg_locate.sv =====
module cfpg_locate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  cfpg_pkg::front_t   front,
  output cfpg_pkg::locate_t  locate
);

  cfpg_pkg::locate_t locate_r;
  cfpg_pkg::locate_t locate_nxt;
  cfpg_pkg::slot_t slot;
  logic colon_row;
  logic btn_hit;

  assign slot = cfpg_pkg::slot_of(front.rx);
  assign colon_row = ((front.ry >= cfpg_pkg::RY_W'(cfpg_pkg::GLYPH_ZOOM)) &&
                      (front.ry < cfpg_pkg::RY_W'(cfpg_pkg::GLYPH_ZOOM +
                                                  cfpg_pkg::DOT_SIZE))) ||
                     ((front.ry >= cfpg_pkg::RY_W'(4 * cfpg_pkg::GLYPH_ZOOM)) &&
                      (front.ry < cfpg_pkg::RY_W'(4 * cfpg_pkg::GLYPH_ZOOM +
                                                  cfpg_pkg::DOT_SIZE)));
  assign btn_hit = front.btn_in && cfpg_pkg::close_mask(front.btn_dx, front.btn_dy);

  // background layers, slot decode and digit select
  always_comb begin
    locate_nxt.valid = front.valid;
    locate_nxt.outside = front.outside;
    if (btn_hit) locate_nxt.base = cfpg_pkg::PAINT_CLOSE;
    else if (front.panel) locate_nxt.base = cfpg_pkg::PAINT_PANEL;
    else if (front.border) locate_nxt.base = cfpg_pkg::PAINT_BORDER;
    else locate_nxt.base = cfpg_pkg::PAINT_BACK;
    locate_nxt.col = slot.col;
    locate_nxt.row = cfpg_pkg::row_of(front.ry);
    locate_nxt.glyph_en = front.clk_in;
    locate_nxt.secs = 1'b0;
    locate_nxt.colon_hit = 1'b0;
    case (slot.kind)
      cfpg_pkg::SLOT_D0: locate_nxt.digit = front.digits[0];
      cfpg_pkg::SLOT_D1: locate_nxt.digit = front.digits[1];
      cfpg_pkg::SLOT_D2: locate_nxt.digit = front.digits[2];
      cfpg_pkg::SLOT_D3: locate_nxt.digit = front.digits[3];
      cfpg_pkg::SLOT_D4: begin
        locate_nxt.digit = front.digits[4];
        locate_nxt.secs = 1'b1;
      end
      cfpg_pkg::SLOT_D5: begin
        locate_nxt.digit = front.digits[5];
        locate_nxt.secs = 1'b1;
      end
      cfpg_pkg::SLOT_COLON: begin
        locate_nxt.digit = 4'd0;
        locate_nxt.glyph_en = 1'b0;
        locate_nxt.colon_hit = front.clk_in && colon_row;
      end
      default: begin
        locate_nxt.digit = 4'd0;
        locate_nxt.glyph_en = 1'b0;
      end
    endcase
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locate_r.valid <= 1'b0;
    end else if (adv) begin
      locate_r <= locate_nxt;
    end
  end

  assign locate = locate_r;

endmodule

// ===== rtl/cfpg_shade.sv =====
`include "clock_face_pixel_generator_macros.svh"

module cfpg_shade (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  cfpg_pkg::locate_t  locate,
  output logic               out_valid,
  output logic [31:0]        out_pixel_color
);

  logic out_valid_r;
  logic [31:0] color_r;
  logic [31:0] color_nxt;
  logic glyph_hit;
  cfpg_pkg::paint_t paint;

  assign glyph_hit = locate.glyph_en &&
                     cfpg_pkg::font_bit(locate.digit, locate.row, locate.col);

  // top layers over the base color
  always_comb begin
    if (locate.outside) paint = cfpg_pkg::PAINT_NONE;
    else if (glyph_hit) paint = locate.secs ? cfpg_pkg::PAINT_SECS : cfpg_pkg::PAINT_TIME;
    else if (locate.colon_hit) paint = cfpg_pkg::PAINT_BORDER;
    else paint = locate.base;
    color_nxt = cfpg_pkg::argb(paint);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= locate.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      color_r <= color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel_color = color_r;

  `CFPG_ASSERT_NXT(a_outside_black, clk, rst_n, adv && locate.valid && locate.outside, color_r == 32'h0)
  `CFPG_ASSERT_NXT(a_digit_opaque, clk, rst_n, adv && locate.valid && !locate.outside, color_r[31:24] == 8'hff)

endmodule

// ===== dv/clock_face_pixel_generator_test.sv =====
`timescale 1ns / 100ps

module clock_face_pixel_generator_test;

  // layout of the clock face
  localparam int CLOCK_SPAN_X = 205;
  localparam int CLOCK_SPAN_Y = 35;
  localparam int SCALE_PX = 5;
  localparam int GLYPH_PX = 25;
  localparam int GLYPH_ROWS_PX = 35;
  localparam int DIGIT_STEP = 30;
  localparam int COLON_PX = 10;
  localparam int COLON_STEP = 15;
  localparam int BTN_PX = 18;
  localparam int BTN_MARGIN = 10;

  // palette
  localparam logic [31:0] ARGB_BACK = 32'hff101722;
  localparam logic [31:0] ARGB_PANEL = 32'hff182333;
  localparam logic [31:0] ARGB_BORDER = 32'hff38b2ac;
  localparam logic [31:0] ARGB_TIME = 32'hffedf2f7;
  localparam logic [31:0] ARGB_SECS = 32'hff63d5cf;
  localparam logic [31:0] ARGB_CLOSE = 32'hfffc8181;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES = 13;

  typedef struct {
    int px;
    int py;
    logic [31:0] color;
  } pixel_note_t;

  // expected colors of accepted requests, oldest first
  class pixel_color_scoreboard;
    int frame_w;
    int frame_h;
    int errors;
    pixel_note_t expected_colors[$];

    function new();
      frame_w = 640;
      frame_h = 480;
      errors = 0;
    endfunction

    function void set_frame(int w, int h);
      frame_w = w & 'h1fff;
      frame_h = h & 'h1fff;
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function bit in_rect(int px, int py, int x, int y, int w, int h);
      if (w <= 0 || h <= 0) return 1'b0;
      return px >= x && px < x + w && py >= y && py < y + h;
    endfunction

    function logic [4:0] font_row(int d, int r);
      logic [34:0] rows;
      case (d)
        0: rows = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
        1: rows = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
        2: rows = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
        3: rows = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
        4: rows = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
        5: rows = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
        6: rows = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
        7: rows = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
        8: rows = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
        9: rows = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
        default: rows = '0;
      endcase
      return rows[34 - 5 * r -: 5];
    endfunction

    function bit glyph_lit(int px, int py, int x, int y, int d);
      int dx;
      int dy;
      logic [4:0] row;
      dx = px - x;
      dy = py - y;
      if (d < 0 || d > 9) return 1'b0;
      if (dx < 0 || dx >= GLYPH_PX || dy < 0 || dy >= GLYPH_ROWS_PX) return 1'b0;
      row = font_row(d, dy / SCALE_PX);
      return row[4 - dx / SCALE_PX];
    endfunction

    // outline plus the two diagonals of the x
    function bit close_lit(int px, int py, int w);
      int left;
      int top;
      left = w - BTN_MARGIN - BTN_PX;
      top = BTN_MARGIN;
      if (in_rect(px, py, left, top, BTN_PX, 2) ||
          in_rect(px, py, left, top + BTN_PX - 2, BTN_PX, 2) ||
          in_rect(px, py, left, top, 2, BTN_PX) ||
          in_rect(px, py, left + BTN_PX - 2, top, 2, BTN_PX))
        return 1'b1;
      for (int k = 5; k < BTN_PX - 5; k++) begin
        if (in_rect(px, py, left + k, top + k, 2, 2) ||
            in_rect(px, py, left + BTN_PX - k - 2, top + k, 2, 2))
          return 1'b1;
      end
      return 1'b0;
    endfunction

    // painter order: background, border, panel, close button, digits and colons
    function logic [31:0] paint_pixel(int px, int py, int hr, int mn, int sc);
      int digits[6];
      int x;
      int y;
      logic [31:0] color;
      if (px >= frame_w || py >= frame_h) return 32'h0;
      color = ARGB_BACK;
      if (in_rect(px, py, 2, 2, frame_w - 4, frame_h - 4)) color = ARGB_BORDER;
      if (in_rect(px, py, 5, 5, frame_w - 10, frame_h - 10)) color = ARGB_PANEL;
      if (close_lit(px, py, frame_w)) color = ARGB_CLOSE;
      digits[0] = hr / 10;
      digits[1] = hr % 10;
      digits[2] = mn / 10;
      digits[3] = mn % 10;
      digits[4] = sc / 10;
      digits[5] = sc % 10;
      x = (frame_w - CLOCK_SPAN_X) / 2;
      y = (frame_h - CLOCK_SPAN_Y) / 2;
      for (int i = 0; i < 6; i++) begin
        if (glyph_lit(px, py, x, y, digits[i])) color = (i >= 4) ? ARGB_SECS : ARGB_TIME;
        x += DIGIT_STEP;
        if (i == 1 || i == 3) begin
          if (in_rect(px, py, x, y + SCALE_PX, COLON_PX, COLON_PX) ||
              in_rect(px, py, x, y + 4 * SCALE_PX, COLON_PX, COLON_PX))
            color = ARGB_BORDER;
          x += COLON_STEP;
        end
      end
      return color;
    endfunction

    function void note_request(int px, int py, int hr, int mn, int sc);
      pixel_note_t n;
      n.px = px;
      n.py = py;
      n.color = paint_pixel(px, py, hr, mn, sc);
      expected_colors.push_back(n);
    endfunction

    task check_result(logic [31:0] color);
      pixel_note_t n;
      if (expected_colors.size() == 0) begin
        report($sformatf("color %08h with no request waiting", color));
      end else begin
        n = expected_colors.pop_front();
        if (color !== n.color)
          report($sformatf("pixel (%0d,%0d) frame %0dx%0d: color %08h, expected %08h",
                           n.px, n.py, frame_w, frame_h, color, n.color));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [cfpg_pkg::CW-1:0] in_pixel_x = '0;
  logic [cfpg_pkg::CW-1:0] in_pixel_y = '0;
  logic [4:0] in_hour = '0;
  logic [5:0] in_minute = '0;
  logic [5:0] in_second = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_pixel_color;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = cfpg_pkg::REG_FRAME_WIDTH;
  logic [cfpg_pkg::FW-1:0] cfg_data = '0;

  pixel_color_scoreboard sb;
  int idle_pct = 29;
  int stall_cycles = 0;

  int phase_w[NUM_PHASES] = '{1, 0, 30, 205, 206, 4096, 8191, 10, 1920, -1, 320, -1, 640};
  int phase_h[NUM_PHASES] = '{1, 0, 30, 35, 36, 4096, 8191, 10, 1080, -1, 240, -1, 480};

  clock_face_pixel_generator u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .in_hour(in_hour),
    .in_minute(in_minute),
    .in_second(in_second),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel_color(out_pixel_color),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(int'(in_pixel_x), int'(in_pixel_y), int'(in_hour),
                      int'(in_minute), int'(in_second));
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_pixel_color);
  end

  // random backpressure on results
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_pixel(int x, int y, int hr, int mn, int sc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= 12'(x);
    in_pixel_y <= 12'(y);
    in_hour <= 5'(hr);
    in_minute <= 6'(mn);
    in_second <= 6'(sc);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // pixel aimed at the clock, the close button, the frame edges or anywhere
  task automatic send_random_pixel();
    int w;
    int h;
    int x;
    int y;
    int hr;
    int mn;
    int sc;
    int region;
    w = sb.frame_w;
    h = sb.frame_h;
    region = $urandom_range(9);
    if (region <= 4) begin
      x = (w - CLOCK_SPAN_X) / 2 + $urandom_range(0, CLOCK_SPAN_X + 9) - 5;
      y = (h - CLOCK_SPAN_Y) / 2 + $urandom_range(0, CLOCK_SPAN_Y + 9) - 5;
    end else if (region <= 6) begin
      x = w - BTN_MARGIN - BTN_PX - 3 + $urandom_range(0, 23);
      y = BTN_MARGIN - 3 + $urandom_range(0, 23);
    end else if (region == 7) begin
      x = $urandom_range(1) ? $urandom_range(0, 7) : w - 1 - $urandom_range(0, 7);
      y = $urandom_range(1) ? $urandom_range(0, 7) : h - 1 - $urandom_range(0, 7);
    end else begin
      x = $urandom_range(4095);
      y = $urandom_range(4095);
    end
    if ($urandom_range(7) == 0) begin
      hr = $urandom_range(31);
      mn = $urandom_range(63);
      sc = $urandom_range(63);
    end else begin
      hr = $urandom_range(23);
      mn = $urandom_range(59);
      sc = $urandom_range(60);
    end
    send_pixel(x & 'hfff, y & 'hfff, hr, mn, sc);
  endtask

  // stop requests and let the pipeline empty; the last request is noted by the next edge
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame(int w, int h);
    drain_pipeline();
    cfg_wr_en <= 1'b1;
    cfg_index <= cfpg_pkg::REG_FRAME_WIDTH;
    cfg_data <= 13'(w);
    @(posedge clk);
    cfg_index <= cfpg_pkg::REG_FRAME_HEIGHT;
    cfg_data <= 13'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_frame(w, h);
  endtask

  initial begin
    int w;
    int h;
    int count;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels at the reset frame size, clock origin at (217,222)
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(2, 2, 0, 0, 0);
    send_pixel(5, 5, 0, 0, 0);
    send_pixel(639, 479, 23, 59, 60);
    send_pixel(640, 10, 12, 34, 56);
    send_pixel(10, 480, 12, 34, 56);
    send_pixel(4095, 4095, 31, 63, 63);
    send_pixel(612, 10, 0, 0, 0);
    send_pixel(617, 15, 0, 0, 0);
    send_pixel(623, 15, 0, 0, 0);
    send_pixel(620, 18, 0, 0, 0);
    send_pixel(629, 27, 0, 0, 0);
    send_pixel(217, 222, 0, 0, 0);
    send_pixel(222, 222, 0, 0, 0);
    send_pixel(372, 222, 0, 0, 0);
    send_pixel(277, 227, 0, 0, 0);
    send_pixel(352, 242, 0, 0, 0);
    send_pixel(421, 256, 8, 8, 8);
    send_pixel(247, 230, 31, 63, 63);
    send_pixel(397, 240, 19, 47, 60);

    // frame size phases, one of them without any idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = (phase_w[p] < 0) ? $urandom_range(1, 4096) : phase_w[p];
      h = (phase_h[p] < 0) ? $urandom_range(1, 4096) : phase_h[p];
      write_frame(w, h);
      idle_pct = (p == 8) ? 0 : 29;
      count = (w <= 1) ? 40 : 165;
      for (int n = 0; n < count; n++) send_random_pixel();
    end

    drain_pipeline();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
